@@ rtl/core/cec_pkg.sv @@
// ----------------------------------------------------------------------------
// Calendar epoch converter package
// Shared opcodes, year bounds and calendar helpers.
// ----------------------------------------------------------------------------
`default_nettype none
package cec_pkg;
  localparam logic OP_TO_SECONDS = 1'b0;
  localparam logic OP_TO_DATE    = 1'b1;

  localparam logic [13:0] EPOCH_YEAR = 14'd2000;
  localparam logic [13:0] LAST_YEAR  = 14'd9999;

  // Leap test by repeated-subtraction-free form: year < 16384.
  function automatic logic is_leap(input logic [13:0] y);
    logic [13:0] q100;
    logic [6:0]  r100;
    q100 = 14'((32'(y) * 32'd10486) >> 20);
    r100 = 7'(y - 14'(q100 * 14'd100));
    if (y[1:0] != 2'b00) return 1'b0;
    if (r100 != 7'd0)    return 1'b1;
    return (q100[1:0] == 2'b00);
  endfunction

  function automatic logic [4:0] month_days(input logic [13:0] y, input logic [3:0] m);
    logic [4:0] d;
    case (m)
      4'd2:                     d = is_leap(y) ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:  d = 5'd30;
      default:                  d = 5'd31;
    endcase
    return d;
  endfunction
endpackage
`default_nettype wire

@@ rtl/core/cec_seq.sv @@
// ----------------------------------------------------------------------------
// Calendar epoch converter sequencer
// Walks months, and years for seconds to date, one step a cycle through one
// shared adder/compare.
// ----------------------------------------------------------------------------
`default_nettype none
module cec_seq (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic        opcode,
  input  wire logic [13:0] given_year,
  input  wire logic [3:0]  given_month,
  input  wire logic [4:0]  given_day,
  input  wire logic [4:0]  given_hour,
  input  wire logic [5:0]  given_minute,
  input  wire logic [5:0]  given_second,
  input  wire logic [31:0] given_seconds,
  output logic             done,
  output logic [31:0]      seconds_total,
  output logic [13:0]      year,
  output logic [3:0]       month,
  output logic [4:0]       day,
  output logic [4:0]       hour,
  output logic [5:0]       minute,
  output logic [5:0]       second,
  output logic [2:0]       weekday,
  output logic             wrapped
);
  import cec_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001, S_SPLIT = 7'b0000010, S_YEAR = 7'b0000100,
    S_MON  = 7'b0001000, S_SEC  = 7'b0010000, S_WDAY = 7'b0100000,
    S_DONE = 7'b1000000
  } state_t;

  state_t      state_r, state_nxt;
  logic        op_r;
  logic [13:0] yr_r, ytgt_r;
  logic [3:0]  mo_r, mtgt_r;
  logic [4:0]  dy_r, hr_r;
  logic [5:0]  mi_r, se_r;
  logic [31:0] acc_r;     // day count
  logic [31:0] secs_r;
  logic [47:0] full_r;
  logic [2:0]  wd_r;
  logic [16:0] rem_r;

  // shared step quantity: length of current year or month
  logic [8:0]  step_len;
  logic        step_ge;
  always_comb begin
    if (state_r == S_YEAR) step_len = is_leap(yr_r) ? 9'd366 : 9'd365;
    else                   step_len = {4'd0, month_days(yr_r, mo_r)};
    step_ge = (acc_r >= {23'd0, step_len});
  end

  // days from the epoch to 1 January of the target year, closed form
  logic [13:0] yprev, yq100;
  logic [31:0] ydays;
  always_comb begin
    yprev = ytgt_r - 14'd1;
    yq100 = 14'((32'(yprev) * 32'd10486) >> 20);
    ydays = 32'(ytgt_r - EPOCH_YEAR) * 32'd365 + 32'(yprev[13:2]) - 32'(yq100)
          + 32'(yq100[13:2]) - 32'd484;
  end

  // (days + 6) mod 7 by reciprocal; day counts stay below 2^22
  logic [21:0] wd_sum, wd_q;
  logic [2:0]  wd_calc;
  always_comb begin
    wd_sum  = 22'(acc_r) + 22'd6;
    wd_q    = 22'((48'(wd_sum) * 48'd9586981) >> 26);
    wd_calc = 3'(wd_sum - 22'(wd_q * 22'd7));
  end

  // time of day: hour from the day remainder, then minute from what is left
  logic [16:0] hr_q;
  logic [5:0]  mi_q;
  always_comb begin
    hr_q = 17'((48'(rem_r) * 48'd298262) >> 30);
    mi_q = 6'((32'(rem_r) * 32'd17477) >> 20);
  end

  logic [13:0] cy;
  logic [3:0]  cm;
  logic [4:0]  cmax, cd;
  always_comb begin
    cy = given_year < EPOCH_YEAR ? EPOCH_YEAR :
         (given_year > LAST_YEAR ? LAST_YEAR : given_year);
    cm = given_month == 4'd0 ? 4'd1 : (given_month > 4'd12 ? 4'd12 : given_month);
    cmax = month_days(cy, cm);
    cd = given_day == 5'd0 ? 5'd1 : (given_day > cmax ? cmax : given_day);
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (start) state_nxt = op_r ? S_SPLIT : S_YEAR;
      S_SPLIT: state_nxt = S_YEAR;
      S_YEAR:  if (!op_r || !step_ge) state_nxt = S_MON;
      S_MON:   if (op_r ? (!step_ge || mo_r == 4'd12) : (mo_r == mtgt_r))
                 state_nxt = op_r ? S_WDAY : S_SEC;
      S_SEC:   state_nxt = S_WDAY;
      S_WDAY:  state_nxt = S_DONE;
      S_DONE:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else if (state_r == S_IDLE && start) state_r <= opcode ? S_SPLIT : S_YEAR;
    else if (state_r != S_IDLE) state_r <= state_nxt;
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: if (start) begin
        op_r <= opcode;
        secs_r <= given_seconds;
        yr_r <= EPOCH_YEAR; mo_r <= 4'd1;
        ytgt_r <= cy; mtgt_r <= cm; dy_r <= cd;
        hr_r <= given_hour > 5'd23 ? 5'd23 : given_hour;
        mi_r <= given_minute > 6'd59 ? 6'd59 : given_minute;
        se_r <= given_second > 6'd59 ? 6'd59 : given_second;
        // opcode 1: days = s / 86400 by reciprocal, exact over 32 bits
        acc_r <= opcode ? 32'((64'(given_seconds) * 64'd3257812231) >> 48) : 32'd0;
      end
      S_SPLIT: begin
        rem_r <= 17'(secs_r - 32'(acc_r * 32'd86400));
        wd_r <= wd_calc;
      end
      S_YEAR: begin
        if (op_r) begin
          if (step_ge) begin acc_r <= acc_r - {23'd0, step_len}; yr_r <= yr_r + 14'd1; end
        end else begin
          acc_r <= ydays; yr_r <= ytgt_r;
        end
      end
      S_MON: begin
        if (op_r) begin
          if (step_ge && mo_r != 4'd12) begin
            acc_r <= acc_r - {23'd0, step_len}; mo_r <= mo_r + 4'd1;
          end else dy_r <= 5'(acc_r) + 5'd1;
        end else if (mo_r != mtgt_r) begin
          acc_r <= acc_r + {23'd0, step_len}; mo_r <= mo_r + 4'd1;
        end
      end
      S_SEC: begin
        full_r <= 48'(acc_r + 32'(dy_r) - 32'd1) * 48'd86400 + 48'(hr_r) * 48'd3600
                + 48'(mi_r) * 48'd60 + 48'(se_r);
        // days since epoch for weekday: epoch was Saturday
        acc_r <= acc_r + 32'(dy_r) - 32'd1;
      end
      S_WDAY: begin
        if (op_r) begin
          hr_r <= 5'(hr_q);
          rem_r <= rem_r - hr_q * 17'd3600;
        end else wd_r <= wd_calc;
      end
      S_DONE: begin
        if (op_r) begin
          mi_r <= mi_q;
          se_r <= 6'(rem_r - 17'(mi_q) * 17'd60);
        end
      end
      default: ;
    endcase
  end

  assign done = (state_r == S_DONE);
  assign seconds_total = op_r ? secs_r : full_r[31:0];
  assign wrapped = op_r ? 1'b0 : (full_r[47:32] != 16'd0);
  assign year = yr_r; assign month = mo_r; assign day = dy_r;
  assign hour = hr_r; assign minute = mi_r; assign second = se_r;
  assign weekday = wd_r;
endmodule
`default_nettype wire

@@ rtl/core/calendar_epoch_converter_top.sv @@
// ----------------------------------------------------------------------------
// Calendar epoch converter
// Date/time to seconds since 2000-01-01 and back.
// ----------------------------------------------------------------------------
// Usage: present a transaction on in_* with in_valid; in_ready is high only
// while the sequencer is idle and the output register is empty. Opcode 0
// clamps the date, finds the days up to its year in one step, walks the
// months through one adder, and gives seconds, weekday and a wrap flag.
// Opcode 1 splits the count into days and time of day, then walks years and
// months down through the same adder.
// On opcode 1 the year walk stops at 2136 at the latest. One item at a time:
// the next is taken at the earliest the cycle after the result transaction.
// The result waits in out_* with out_valid until out_ready; no new item is
// taken while it waits. Synchronous reset empties the block.
// ----------------------------------------------------------------------------
`default_nettype none
module calendar_epoch_converter_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_opcode,
  input  wire logic [13:0] in_given_year,
  input  wire logic [3:0]  in_given_month,
  input  wire logic [4:0]  in_given_day,
  input  wire logic [4:0]  in_given_hour,
  input  wire logic [5:0]  in_given_minute,
  input  wire logic [5:0]  in_given_second,
  input  wire logic [31:0] in_given_seconds,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      out_seconds_total,
  output logic [13:0]      out_year,
  output logic [3:0]       out_month,
  output logic [4:0]       out_day,
  output logic [4:0]       out_hour,
  output logic [5:0]       out_minute,
  output logic [5:0]       out_second,
  output logic [2:0]       out_weekday,
  output logic             out_wrapped
);
  import cec_pkg::*;

  logic busy_r, done, start;
  assign in_ready = !busy_r && !out_valid;
  assign start = in_valid && in_ready;

  cec_seq u_seq (
    .clk, .rst_n, .start, .opcode(in_opcode),
    .given_year(in_given_year), .given_month(in_given_month),
    .given_day(in_given_day), .given_hour(in_given_hour),
    .given_minute(in_given_minute), .given_second(in_given_second),
    .given_seconds(in_given_seconds), .done,
    .seconds_total(out_seconds_total), .year(out_year), .month(out_month),
    .day(out_day), .hour(out_hour), .minute(out_minute), .second(out_second),
    .weekday(out_weekday), .wrapped(out_wrapped)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; out_valid <= 1'b0;
    end else begin
      if (start) busy_r <= 1'b1;
      else if (done) busy_r <= 1'b0;
      if (done) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> !in_ready) else $error("accept while busy");
  a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done |-> busy_r) else $error("done without item");
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_month >= 4'd1 && out_month <= 4'd12 && out_weekday <= 3'd6))
    else $error("result out of range");
endmodule
`default_nettype wire

@@ tb/cec_checker.sv @@
// ----------------------------------------------------------------------------
// Calendar epoch converter checker
// Watches both channels, computes the expected conversion for every accepted
// request and compares each returned transaction field by field.
// ----------------------------------------------------------------------------
module cec_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        in_opcode,
  input  logic [13:0] in_given_year,
  input  logic [3:0]  in_given_month,
  input  logic [4:0]  in_given_day,
  input  logic [4:0]  in_given_hour,
  input  logic [5:0]  in_given_minute,
  input  logic [5:0]  in_given_second,
  input  logic [31:0] in_given_seconds,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [31:0] out_seconds_total,
  input  logic [13:0] out_year,
  input  logic [3:0]  out_month,
  input  logic [4:0]  out_day,
  input  logic [4:0]  out_hour,
  input  logic [5:0]  out_minute,
  input  logic [5:0]  out_second,
  input  logic [2:0]  out_weekday,
  input  logic        out_wrapped,
  output int          fail_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import cec_pkg::*;

  typedef struct packed {
    logic [31:0] secs;
    logic [13:0] yr;
    logic [3:0]  mo;
    logic [4:0]  dy;
    logic [4:0]  hr;
    logic [5:0]  mi;
    logic [5:0]  se;
    logic [2:0]  wd;
    logic        wrap;
  } conv_t;

  conv_t expected_q[$];

  function automatic bit leap(longint y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic longint mlen(longint y, longint m);
    if (m == 2) return leap(y) ? 29 : 28;
    if (m == 4 || m == 6 || m == 9 || m == 11) return 30;
    return 31;
  endfunction

  function automatic conv_t convert(logic op, logic [13:0] gy, logic [3:0] gm,
                                    logic [4:0] gd, logic [4:0] gh, logic [5:0] gmi,
                                    logic [5:0] gs, logic [31:0] gsec);
    conv_t r;
    longint y, m, d, h, mi, s, days, full, a, yy, mm, rem;
    if (op == OP_TO_SECONDS) begin
      y = gy; m = gm; d = gd; h = gh; mi = gmi; s = gs;
      if (y < 2000) y = 2000;
      if (y > 9999) y = 9999;
      if (m < 1) m = 1;
      if (m > 12) m = 12;
      if (d < 1) d = 1;
      if (d > mlen(y, m)) d = mlen(y, m);
      if (h > 23) h = 23;
      if (mi > 59) mi = 59;
      if (s > 59) s = 59;
      days = 365 * (y - 2000) + ((y - 1) / 4 - (y - 1) / 100 + (y - 1) / 400)
           - (1999 / 4 - 1999 / 100 + 1999 / 400);
      for (longint k = 1; k < m; k++) days += mlen(y, k);
      days += d - 1;
      full = days * 86400 + h * 3600 + mi * 60 + s;
      r.secs = full[31:0];
      r.wrap = (full > 64'hFFFF_FFFF);
      a = (m <= 2) ? 1 : 0;
      yy = y - a;
      mm = m + 12 * a - 2;
      r.wd = 3'((d + yy + yy / 4 - yy / 100 + yy / 400 + (31 * mm) / 12) % 7);
    end else begin
      r.secs = gsec;
      r.wrap = 1'b0;
      rem = gsec % 86400;
      days = gsec / 86400;
      h = rem / 3600;
      mi = (rem % 3600) / 60;
      s = rem % 60;
      r.wd = 3'((days + 6) % 7);
      y = 2000;
      while (days >= (leap(y) ? 366 : 365)) begin
        days -= leap(y) ? 366 : 365;
        y++;
      end
      m = 1;
      while (days >= mlen(y, m) && m < 12) begin
        days -= mlen(y, m);
        m++;
      end
      d = days + 1;
    end
    r.yr = 14'(y); r.mo = 4'(m); r.dy = 5'(d);
    r.hr = 5'(h); r.mi = 6'(mi); r.se = 6'(s);
    return r;
  endfunction

  task automatic compare_field(string name, longint exp_v, longint act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  initial begin
    fail_count = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    conv_t e;
    if (rst_n && in_valid && in_ready)
      expected_q.push_back(convert(in_opcode, in_given_year, in_given_month,
                                   in_given_day, in_given_hour, in_given_minute,
                                   in_given_second, in_given_seconds));
    if (rst_n && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        $error("unexpected result transaction");
        fail_count++;
      end else begin
        e = expected_q.pop_front();
        compare_field("seconds_total", e.secs, out_seconds_total);
        compare_field("year", e.yr, out_year);
        compare_field("month", e.mo, out_month);
        compare_field("day", e.dy, out_day);
        compare_field("hour", e.hr, out_hour);
        compare_field("minute", e.mi, out_minute);
        compare_field("second", e.se, out_second);
        compare_field("weekday", e.wd, out_weekday);
        compare_field("wrapped", e.wrap, out_wrapped);
      end
    end
    pending <= expected_q.size();
  end
endmodule

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// Calendar epoch converter testbench
// Drives directed corner dates and random conversions both ways with random
// gaps on both channels; the checker predicts and compares the results.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import cec_pkg::*;

  localparam longint CYCLE_LIMIT = 64'd40_000_000;

  logic        clk, rst_n;
  logic        in_valid, in_ready, in_opcode;
  logic [13:0] in_given_year;
  logic [3:0]  in_given_month;
  logic [4:0]  in_given_day, in_given_hour;
  logic [5:0]  in_given_minute, in_given_second;
  logic [31:0] in_given_seconds;
  logic        out_valid, out_ready, out_wrapped;
  logic [31:0] out_seconds_total;
  logic [13:0] out_year;
  logic [3:0]  out_month;
  logic [4:0]  out_day, out_hour;
  logic [5:0]  out_minute, out_second;
  logic [2:0]  out_weekday;
  int          fail_count, pending;
  longint      cycles;

  calendar_epoch_converter_top uut (.*);

  cec_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  // Random back-pressure on the result side; some stretches never stall.
  initial begin
    int n;
    out_ready = 1'b0;
    forever begin
      n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 3);
      repeat (n) @(posedge clk) out_ready <= 1'b0;
      @(posedge clk) out_ready <= 1'b1;
      while (!(out_valid && out_ready)) @(posedge clk);
    end
  end

  task automatic send(logic op, int y, int mo, int d, int h, int mi, int s,
                      logic [31:0] secs);
    int gap;
    in_valid         <= 1'b1;
    in_opcode        <= op;
    in_given_year    <= 14'(y);
    in_given_month   <= 4'(mo);
    in_given_day     <= 5'(d);
    in_given_hour    <= 5'(h);
    in_given_minute  <= 6'(mi);
    in_given_second  <= 6'(s);
    in_given_seconds <= secs;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    // stay asserted when the next transaction follows at once
    gap = $urandom_range(0, 3);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_random();
    int y;
    // Mix full-range years with years near the wrap boundary.
    case ($urandom_range(0, 9))
      0:       y = $urandom_range(0, 16383);
      1:       y = $urandom_range(0, 9999);
      2:       y = $urandom_range(2000, 2200);
      default: y = $urandom_range(1990, 2140);
    endcase
    if ($urandom_range(0, 1))
      send(OP_TO_SECONDS, y, $urandom_range(0, 15), $urandom_range(0, 31),
           $urandom_range(0, 31), $urandom_range(0, 63), $urandom_range(0, 63),
           $urandom);
    else
      send(OP_TO_DATE, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
           $urandom);
  endtask

  initial begin
    rst_n = 1'b0; in_valid = 1'b0; in_opcode = 1'b0;
    in_given_year = '0; in_given_month = '0; in_given_day = '0;
    in_given_hour = '0; in_given_minute = '0; in_given_second = '0;
    in_given_seconds = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // epoch, clamps low and high, leap days, wrap boundary
    send(OP_TO_SECONDS, 2000, 1, 1, 0, 0, 0, 32'hFFFF_FFFF);
    send(OP_TO_SECONDS, 0, 0, 0, 0, 0, 0, 0);
    send(OP_TO_SECONDS, 16383, 15, 31, 31, 63, 63, 0);
    send(OP_TO_SECONDS, 9999, 12, 31, 23, 59, 59, 0);
    send(OP_TO_SECONDS, 2000, 2, 31, 12, 30, 30, 0);
    send(OP_TO_SECONDS, 2100, 2, 29, 1, 1, 1, 0);
    send(OP_TO_SECONDS, 2024, 2, 29, 5, 6, 7, 0);
    send(OP_TO_SECONDS, 2400, 2, 30, 0, 0, 0, 0);
    send(OP_TO_SECONDS, 2136, 2, 7, 6, 28, 15, 0);
    send(OP_TO_SECONDS, 2136, 2, 7, 6, 28, 16, 0);
    send(OP_TO_SECONDS, 2023, 4, 31, 0, 0, 0, 0);
    send(OP_TO_SECONDS, 8191, 10, 0, 16, 32, 32, 0);
    send(OP_TO_DATE, 16383, 15, 31, 31, 63, 63, 32'd0);
    send(OP_TO_DATE, 0, 0, 0, 0, 0, 0, 32'hFFFF_FFFF);
    send(OP_TO_DATE, 0, 0, 0, 0, 0, 0, 32'd86399);
    send(OP_TO_DATE, 0, 0, 0, 0, 0, 0, 32'd5097600);
    send(OP_TO_DATE, 0, 0, 0, 0, 0, 0, 32'd31622400);
    send(OP_TO_DATE, 0, 0, 0, 0, 0, 0, 32'h8000_0000);
    send(OP_TO_DATE, 0, 0, 0, 0, 0, 0, 32'h5555_5555);
    send(OP_TO_DATE, 0, 0, 0, 0, 0, 0, 32'hAAAA_AAAA);

    // hold off until the converter drains once
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);

    repeat (1700) send_random();

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0 || out_valid) @(posedge clk);
    repeat (50) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end
endmodule

@@ filelist.f @@
rtl/core/cec_pkg.sv
rtl/core/cec_seq.sv
rtl/core/calendar_epoch_converter_top.sv
tb/cec_checker.sv
tb/tb_top.sv
